>>> hw/rtl/lidar_scan_packet_deframer_defines.svh
// Assertion helpers for the scan packet deframer.
`ifndef LIDAR_SCAN_PACKET_DEFRAMER_DEFINES_SVH
`define LIDAR_SCAN_PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lspd_pkg.sv
package lspd_pkg;

    localparam int STEP_W = 23;
    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam logic [15:0] HDR_WORD  = 16'h55AA;

    // angles in 1/64 degree
    localparam logic [14:0] ANG_90  = 15'd5760;
    localparam logic [14:0] ANG_270 = 15'd17280;
    localparam logic [15:0] ANG_360 = 16'd23040;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CSUM_ERR = 2'd1;
    localparam logic [1:0] ST_NO_SAMP  = 2'd2;

    localparam logic [15:0] SKIP_MAX = 16'hFFFF;

    // snapshot of a finished packet, parser -> report sequencer
    typedef struct packed {
        logic [7:0]  type_b;
        logic [7:0]  count;
        logic [15:0] first_word;
        logic [15:0] last_word;
        logic        xor_ok;
        logic [15:0] skipped;
    } pkt_t;

endpackage

>>> hw/rtl/lspd_frame.sv
module lspd_frame (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_en,
    input  logic [7:0]    rx_byte,
    output logic          pkt_valid,
    output lspd_pkg::pkt_t pkt
);
    import lspd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_HEAD  = 3'd2,
        PH_SAMP  = 3'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [8:0]  pos_reg, pos_next;
    logic [15:0] xor_reg, xor_next;
    logic [7:0]  low_reg, low_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] last_reg, last_next;
    logic [15:0] skip_reg, skip_next;
    logic        pkt_valid_reg;
    pkt_t        pkt_reg;

    logic [15:0] word;
    logic [1:0]  skip_inc;
    logic [16:0] skip_sum;
    logic        end_now;

    assign word     = {rx_byte, low_reg};
    assign skip_sum = {1'b0, skip_reg} + {15'd0, skip_inc};

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        low_next   = low_reg;
        type_next  = type_reg;
        count_next = count_reg;
        first_next = first_reg;
        last_next  = last_reg;
        skip_inc   = 2'd0;
        end_now    = 1'b0;

        case (phase_reg)
            PH_HUNT2:
            begin
                if (rx_byte == HDR_SECOND)
                begin
                    phase_next = PH_HEAD;
                    pos_next   = 9'd0;
                    xor_next   = HDR_WORD;
                end
                else if (rx_byte == HDR_FIRST)
                begin
                    skip_inc = 2'd1;   // drop the earlier AA
                end
                else
                begin
                    skip_inc   = 2'd2;
                    phase_next = PH_HUNT1;
                end
            end
            PH_HEAD:
            begin
                if (!pos_reg[0])
                    low_next = rx_byte;
                else
                    xor_next = xor_reg ^ word;
                if (pos_reg == 9'd0) type_next  = rx_byte;
                if (pos_reg == 9'd1) count_next = rx_byte;
                if (pos_reg == 9'd3) first_next = word;
                if (pos_reg == 9'd5) last_next  = word;
                if (pos_reg >= 9'd7)
                begin
                    if (count_reg == 8'd0)
                        end_now = 1'b1;
                    else
                    begin
                        phase_next = PH_SAMP;
                        pos_next   = 9'd0;
                    end
                end
                else
                    pos_next = pos_reg + 9'd1;
            end
            PH_SAMP:
            begin
                if (!pos_reg[0])
                    low_next = rx_byte;
                else
                    xor_next = xor_reg ^ word;
                if (({1'b0, pos_reg} + 10'd1) >= {1'b0, count_reg, 1'b0})
                    end_now = 1'b1;
                else
                    pos_next = pos_reg + 9'd1;
            end
            default:
            begin
                // first header byte hunt, unused codes too
                if (rx_byte == HDR_FIRST)
                    phase_next = PH_HUNT2;
                else
                    skip_inc = 2'd1;
            end
        endcase

        skip_next = skip_sum[16] ? SKIP_MAX : skip_sum[15:0];
        if (end_now)
        begin
            phase_next = PH_HUNT1;
            pos_next   = 9'd0;
            skip_next  = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT1;
            pos_reg       <= 9'd0;
            xor_reg       <= 16'd0;
            low_reg       <= 8'd0;
            type_reg      <= 8'd0;
            count_reg     <= 8'd0;
            first_reg     <= 16'd0;
            last_reg      <= 16'd0;
            skip_reg      <= 16'd0;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            pkt_valid_reg <= byte_en & end_now;
            if (byte_en)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                xor_reg   <= xor_next;
                low_reg   <= low_next;
                type_reg  <= type_next;
                count_reg <= count_next;
                first_reg <= first_next;
                last_reg  <= last_next;
                skip_reg  <= skip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_en && end_now)
        begin
            pkt_reg.type_b     <= type_next;
            pkt_reg.count      <= count_next;
            pkt_reg.first_word <= first_next;
            pkt_reg.last_word  <= last_next;
            pkt_reg.xor_ok     <= (xor_next == 16'd0);
            pkt_reg.skipped    <= skip_reg;
        end
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

endmodule

>>> hw/rtl/lspd_divider.sv
// Restoring divider, one quotient bit per cycle, 8-bit divisor.
module lspd_divider #(
    parameter int NUM_W = 23
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [7:0]       den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] n_reg, n_next;
    logic [7:0]       rem_reg, rem_next;
    logic [7:0]       den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [8:0]       trial;
    logic             fits;

    assign trial = {rem_reg, n_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next = fits ? 8'(trial - {1'b0, den_reg}) : trial[7:0];
        n_next   = {n_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            n_reg   <= num;
            rem_reg <= 8'd0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            n_reg   <= n_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = n_reg;

endmodule

>>> hw/rtl/lidar_scan_packet_deframer.sv
// Channel   Dir  Width  Contents (low bit first)
// s_axis    in   8      tdata: rx_byte
// m_axis    out  88     tdata: status, scan_start, scan_freq, sample_count,
//                       start_angle, end_angle, angle_step, step_reused,
//                       skipped_bytes
//
// Each received byte is accepted in idle, then passes through the parse state.
// A packet that needs an angle step then runs its 15 + STEP_FRACTION_BITS bit
// numerator through the restoring divider (one quotient bit per cycle).
// Reset (rst_n, async) returns to the header hunt; no clearing pass.
// s_tready is low while parsing or dividing, and while an unread report
// sits in the output register.
module lidar_scan_packet_deframer #(
    parameter int STEP_FRACTION_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [2] scan_start, [9:3] scan_freq, [17:10] sample_count,
    // [32:18] start_angle, [47:33] end_angle, [70:48] angle_step,
    // [71] step_reused, [87:72] skipped_bytes
    output logic [87:0] m_tdata
);
    import lspd_pkg::*;

    `include "lidar_scan_packet_deframer_defines.svh"

    // numerator is a 15-bit angle span with the fraction bits appended
    localparam int NUM_W  = 15 + STEP_FRACTION_BITS;
    localparam int WIDE_W = (NUM_W > STEP_W) ? NUM_W : STEP_W;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_PARSE = 2'd1,
        S_DIV   = 2'd2
    } state_t;

    state_t            state_reg;
    logic              m_tvalid_reg;
    logic [6:0]        freq_reg;
    logic [STEP_W-1:0] prev_step_reg;
    logic              wrap_reg;

    // report register
    logic [1:0]        status_reg;
    logic              start_reg;
    logic [6:0]        rfreq_reg;
    logic [7:0]        count_reg;
    logic [14:0]       first_reg;
    logic [14:0]       last_reg;
    logic [STEP_W-1:0] step_reg;
    logic              reused_reg;
    logic [15:0]       skip_reg;

    logic              in_acc;
    logic              pkt_valid;
    pkt_t              pkt;

    logic [14:0]       first_ang, last_ang;
    logic [16:0]       span_wrap;
    logic [14:0]       span;
    logic              wrap_case;
    logic              wrap_sat;
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [7:0]        div_den;
    logic              div_busy;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;
    logic [WIDE_W-1:0] quot_wide;
    logic [STEP_W-1:0] step_sat;
    logic [1:0]        pkt_status;
    logic [6:0]        freq_next;

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;

    lspd_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (in_acc),
        .rx_byte   (s_tdata),
        .pkt_valid (pkt_valid),
        .pkt       (pkt)
    );

    // angle words carry a flag in bit 0
    assign first_ang = pkt.first_word[15:1];
    assign last_ang  = pkt.last_word[15:1];
    assign span_wrap = {1'b0, ANG_360} + {2'b0, last_ang} - {2'b0, first_ang};
    // wrap through zero: start past 270 deg, end before 90 deg
    assign wrap_case = (first_ang > ANG_270) && (last_ang < ANG_90);
    // start more than a full turn past the end: span goes negative, step saturates
    assign wrap_sat  = wrap_case && span_wrap[16];
    assign span      = (last_ang >= first_ang) ? (last_ang - first_ang) : span_wrap[14:0];

    always_comb
    begin
        if (pkt.count == 8'd0)
            pkt_status = ST_NO_SAMP;
        else if (!pkt.xor_ok)
            pkt_status = ST_CSUM_ERR;
        else
            pkt_status = ST_OK;

        // start packets with a good status refresh the scan frequency
        if (pkt_status == ST_OK && pkt.type_b[0])
            freq_next = pkt.type_b[7:1];
        else
            freq_next = freq_reg;
    end

    assign div_start = (state_reg == S_PARSE) && pkt_valid && (pkt_status == ST_OK)
                       && (pkt.count != 8'd1)
                       && ((last_ang >= first_ang) || (wrap_case && !wrap_sat));
    assign div_num   = NUM_W'({span, {STEP_FRACTION_BITS{1'b0}}});
    assign div_den   = pkt.count - 8'd1;

    lspd_divider #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign quot_wide = WIDE_W'(div_quot);
    assign step_sat  = (quot_wide > WIDE_W'(STEP_MAX)) ? STEP_MAX : quot_wide[STEP_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            freq_reg      <= 7'd0;
            prev_step_reg <= '0;
            wrap_reg      <= 1'b0;
            status_reg    <= ST_OK;
            start_reg     <= 1'b0;
            rfreq_reg     <= 7'd0;
            count_reg     <= 8'd0;
            first_reg     <= 15'd0;
            last_reg      <= 15'd0;
            step_reg      <= '0;
            reused_reg    <= 1'b0;
            skip_reg      <= 16'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    // a report is only ever pending here
                    if (m_tvalid_reg && m_tready)
                        m_tvalid_reg <= 1'b0;
                    if (in_acc)
                        state_reg <= S_PARSE;
                end
                S_PARSE:
                begin
                    if (pkt_valid)
                    begin
                        status_reg <= pkt_status;
                        start_reg  <= pkt.type_b[0];
                        rfreq_reg  <= freq_next;
                        freq_reg   <= freq_next;
                        count_reg  <= pkt.count;
                        first_reg  <= first_ang;
                        last_reg   <= last_ang;
                        skip_reg   <= pkt.skipped;
                        wrap_reg   <= (last_ang < first_ang);
                        reused_reg <= 1'b0;
                        if (div_start)
                        begin
                            state_reg <= S_DIV;
                            step_reg  <= '0;
                        end
                        else
                        begin
                            state_reg    <= S_IDLE;
                            m_tvalid_reg <= 1'b1;
                            if (pkt_status == ST_OK && pkt.count != 8'd1
                                && last_ang < first_ang)
                            begin
                                if (wrap_case)
                                begin
                                    step_reg      <= STEP_MAX;
                                    prev_step_reg <= STEP_MAX;
                                end
                                else
                                begin
                                    // backward jump that is no wrap: keep the last wrap step
                                    step_reg   <= prev_step_reg;
                                    reused_reg <= 1'b1;
                                end
                            end
                            else
                                step_reg <= '0;
                        end
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        step_reg     <= step_sat;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                        if (wrap_reg)
                            prev_step_reg <= step_sat;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {skip_reg, reused_reg, step_reg, last_reg, first_reg,
                       count_reg, rfreq_reg, start_reg, status_reg};

    `LSPD_ASSERT_NOW(a_no_accept_while_div, div_busy, !s_tready,
        "byte accepted while divider busy")
    `LSPD_ASSERT_NOW(a_done_in_div, div_done, state_reg == S_DIV,
        "divider finished outside divide state")
    `LSPD_ASSERT_NOW(a_reuse_only_ok, m_tvalid_reg && reused_reg, status_reg == ST_OK,
        "step reuse reported on a bad packet")
    `LSPD_ASSERT_NOW(a_bad_no_step, m_tvalid_reg && status_reg != ST_OK, step_reg == '0,
        "angle step on a bad packet")
    `LSPD_ASSERT_NEXT(a_parse_one_cycle, state_reg == S_PARSE, state_reg != S_PARSE,
        "parse state held more than one cycle")

endmodule

>>> sim/lspd_report_checker.sv
module lspd_report_checker #(
    parameter int STEP_FRACTION_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    output int          errors,
    output int          waiting
);
    import lspd_pkg::*;

    typedef enum logic [1:0] {
        HUNT_AA,
        HUNT_55,
        HEADER,
        SAMPLES
    } phase_e;

    // first member sits in the top bits
    typedef struct packed {
        logic [15:0] skipped;
        logic        reused;
        logic [22:0] step;
        logic [14:0] end_ang;
        logic [14:0] start_ang;
        logic [7:0]  count;
        logic [6:0]  freq;
        logic        scan_start;
        logic [1:0]  status;
    } report_t;

    report_t expected_reports [$];

    phase_e      phase;
    logic [8:0]  pos;
    logic [15:0] xor_acc;
    logic [7:0]  low_hold;
    logic [7:0]  type_hold;
    logic [7:0]  count_hold;
    logic [15:0] first_hold;
    logic [15:0] last_hold;
    logic [22:0] wrap_step;
    logic [6:0]  freq_hold;
    logic [15:0] skip_cnt;

    task automatic report_mismatch(input string what, input logic [87:0] got_v,
                                   input logic [87:0] want_v);
        $display("%0t: %s mismatch: got %0h expected %0h", $time, what, got_v, want_v);
        errors++;
    endtask

    function automatic logic [15:0] skip_add(input logic [15:0] cnt, input int n);
        logic [16:0] sum;
        sum = {1'b0, cnt} + 17'(n);
        return sum[16] ? SKIP_MAX : sum[15:0];
    endfunction

    // span is 32-bit unsigned: a negative wrap span comes in huge and saturates
    function automatic logic [22:0] scaled_step(input logic [31:0] span, input logic [7:0] den);
        logic [63:0] q;
        q = ({32'd0, span} << STEP_FRACTION_BITS) / {56'd0, den};
        return (q > {41'd0, STEP_MAX}) ? STEP_MAX : q[22:0];
    endfunction

    // packet end: build the report, update the held step and frequency
    task automatic close_packet();
        report_t r;
        logic [14:0] fa;
        logic [14:0] la;
        fa = first_hold[15:1];
        la = last_hold[15:1];
        r = '0;
        if (count_hold == 8'd0) begin
            r.status = ST_NO_SAMP;
        end
        else if (xor_acc != 16'd0) begin
            r.status = ST_CSUM_ERR;
        end
        else begin
            r.status = ST_OK;
            if (type_hold[0])
                freq_hold = type_hold[7:1];
            if (count_hold != 8'd1) begin
                if (la >= fa) begin
                    r.step = scaled_step(32'(la) - 32'(fa), count_hold - 8'd1);
                end
                else if (fa > ANG_270 && la < ANG_90) begin
                    r.step = scaled_step(32'(ANG_360) + 32'(la) - 32'(fa),
                                         count_hold - 8'd1);
                    wrap_step = r.step;
                end
                else begin
                    r.step = wrap_step;
                    r.reused = 1'b1;
                end
            end
        end
        r.scan_start = type_hold[0];
        r.freq = freq_hold;
        r.count = count_hold;
        r.start_ang = fa;
        r.end_ang = la;
        r.skipped = skip_cnt;
        expected_reports.push_back(r);
        skip_cnt = '0;
        phase = HUNT_AA;
        pos = '0;
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic [15:0] word;
        word = {b, low_hold};
        case (phase)
            HUNT_55: begin
                if (b == HDR_SECOND) begin
                    phase = HEADER;
                    pos = '0;
                    xor_acc = HDR_WORD;
                end
                else if (b == HDR_FIRST) begin
                    skip_cnt = skip_add(skip_cnt, 1);
                end
                else begin
                    skip_cnt = skip_add(skip_cnt, 2);
                    phase = HUNT_AA;
                end
            end
            HEADER: begin
                if (!pos[0])
                    low_hold = b;
                else
                    xor_acc ^= word;
                if (pos == 9'd0) type_hold = b;
                if (pos == 9'd1) count_hold = b;
                if (pos == 9'd3) first_hold = word;
                if (pos == 9'd5) last_hold = word;
                if (pos >= 9'd7) begin
                    if (count_hold == 8'd0) begin
                        close_packet();
                    end
                    else begin
                        phase = SAMPLES;
                        pos = '0;
                    end
                end
                else begin
                    pos = pos + 9'd1;
                end
            end
            SAMPLES: begin
                if (!pos[0])
                    low_hold = b;
                else
                    xor_acc ^= word;
                if ({1'b0, pos} + 10'd1 >= {1'b0, count_hold, 1'b0})
                    close_packet();
                else
                    pos = pos + 9'd1;
            end
            default: begin
                if (b == HDR_FIRST)
                    phase = HUNT_55;
                else
                    skip_cnt = skip_add(skip_cnt, 1);
            end
        endcase
    endtask

    task automatic check_report(input report_t got);
        report_t want;
        if (expected_reports.size() == 0) begin
            report_mismatch("unexpected report", got, '0);
            return;
        end
        want = expected_reports.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.scan_start !== want.scan_start)
            report_mismatch("scan_start", got.scan_start, want.scan_start);
        if (got.freq !== want.freq)
            report_mismatch("scan_freq", got.freq, want.freq);
        if (got.count !== want.count)
            report_mismatch("sample_count", got.count, want.count);
        if (got.start_ang !== want.start_ang)
            report_mismatch("start_angle", got.start_ang, want.start_ang);
        if (got.end_ang !== want.end_ang)
            report_mismatch("end_angle", got.end_ang, want.end_ang);
        if (got.step !== want.step)
            report_mismatch("angle_step", got.step, want.step);
        if (got.reused !== want.reused)
            report_mismatch("step_reused", got.reused, want.reused);
        if (got.skipped !== want.skipped)
            report_mismatch("skipped_bytes", got.skipped, want.skipped);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase = HUNT_AA;
            pos = '0;
            xor_acc = '0;
            low_hold = '0;
            type_hold = '0;
            count_hold = '0;
            first_hold = '0;
            last_hold = '0;
            wrap_step = '0;
            freq_hold = '0;
            skip_cnt = '0;
            expected_reports.delete();
            waiting <= 0;
        end
        else begin
            if (s_tvalid && s_tready)
                predict_byte(s_tdata);
            if (m_tvalid && m_tready)
                check_report(report_t'(m_tdata));
            waiting <= expected_reports.size();
        end
    end

endmodule

>>> sim/tb.sv
module tb;
    import lspd_pkg::*;

    localparam int FRAC         = 8;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no item moving on either side
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int RANDOM_BYTES = 1150;
    localparam int TAIL_CYCLES  = 64;     // > parse + divider + output latency

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [87:0] m_tdata;

    int   errors;
    int   waiting;
    int   bytes_sent = 0;
    logic tx_burst   = 1'b0;  // sender offers back to back
    logic rx_burst   = 1'b0;  // receiver takes back to back
    logic hold_req   = 1'b0;  // ask the receiver for one long hold-off

    lidar_scan_packet_deframer #(
        .STEP_FRACTION_BITS(FRAC)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lspd_report_checker #(
        .STEP_FRACTION_BITS(FRAC)
    ) report_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .waiting  (waiting)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // One byte per item. Random idle gap before it unless bursting; returns on the
    // accepting edge with tvalid still high, so the next call (or the caller)
    // decides what happens to it in that same step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    // Whole packet, little endian words. Checksum word makes the XOR of all
    // words zero; a corrupt packet gets a nonzero error mask on it.
    task automatic send_packet(input logic [7:0] pkt_type, input logic [7:0] count,
                               input logic [15:0] first_w, input logic [15:0] last_w,
                               input logic corrupt);
        logic [15:0] samp [$];
        logic [15:0] csum;
        logic [15:0] w;
        csum = HDR_WORD ^ {count, pkt_type} ^ first_w ^ last_w;
        for (int i = 0; i < count; i++)
        begin
            w = 16'($urandom);
            samp.push_back(w);
            csum ^= w;
        end
        if (corrupt)
            csum ^= 16'($urandom_range(1, 65535));
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(pkt_type);
        send_byte(count);
        send_byte(first_w[7:0]);
        send_byte(first_w[15:8]);
        send_byte(last_w[7:0]);
        send_byte(last_w[15:8]);
        send_byte(csum[7:0]);
        send_byte(csum[15:8]);
        foreach (samp[i])
        begin
            send_byte(samp[i][7:0]);
            send_byte(samp[i][15:8]);
        end
    endtask

    // Angle pairs spread over the step cases: forward span, wrap through
    // zero, backwards without a wrap (step reuse), the wrap boundaries and the extremes.
    task automatic pick_angles(output logic [15:0] first_w, output logic [15:0] last_w);
        logic [14:0] fa;
        logic [14:0] la;
        int mode;
        mode = $urandom_range(0, 6);
        case (mode)
            0, 1:
            begin
                fa = 15'($urandom_range(0, 32767));
                la = 15'($urandom_range(fa, 32767));
            end
            2:
            begin
                fa = 15'($urandom_range(ANG_270 + 1, 32767));
                la = 15'($urandom_range(0, ANG_90 - 1));
            end
            3:
            begin
                fa = 15'($urandom_range(1, ANG_270));
                la = 15'($urandom_range(0, fa - 1));
            end
            4:
            begin
                fa = 15'($urandom_range(ANG_270 + 1, 32767));
                la = 15'($urandom_range(ANG_90, fa - 1));
            end
            5:
            begin
                // right on the wrap limits: at or just above 270, at or just below 90
                fa = ANG_270 + 15'($urandom_range(0, 1));
                la = ANG_90 - 15'($urandom_range(0, 1));
            end
            default:
            begin
                fa = $urandom_range(0, 1) ? 15'd0 : 15'h7FFF;
                la = $urandom_range(0, 1) ? 15'd0 : 15'h7FFF;
            end
        endcase
        first_w = {fa, 1'($urandom_range(0, 1))};
        last_w  = {la, 1'($urandom_range(0, 1))};
    endtask

    function automatic logic [7:0] pick_count();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'($urandom_range(128, 255));
        if (r == 2)
            return 8'd1;
        return 8'($urandom_range(2, 6));
    endfunction

    // Stimulus
    initial
    begin
        int iter;
        int kind;
        logic [15:0] fw;
        logic [15:0] lw;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header hunt: plain junk, a doubled AA (skips the first), then AA
        // followed by a non-55 (skips both).
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(8'h13);
        // zero sample count wins over a bad checksum
        send_packet(8'hFF, 8'd0, 16'hFFFF, 16'h0000, 1'b1);
        // single sample: step stays zero; angles at their extremes
        send_packet(8'h01, 8'd1, 16'h0000, 16'hFFFF, 1'b0);

        // one good packet sent back to back
        tx_burst = 1'b1;
        send_packet(8'hFE, 8'd2, 16'h1000, 16'h2001, 1'b0);
        tx_burst = 1'b0;

        // Random part: mostly well-formed packets, some noise and broken headers.
        bytes_sent = 0;
        iter = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (iter == 4)
                hold_req = 1'b1;  // receiver stalls; the block backs up into its input
            if (iter == 10)
            begin
                // sender pauses until every report is out
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (waiting != 0) @(posedge clk);
            end
            if ($urandom_range(0, 3) == 0)
                tx_burst = !tx_burst;
            kind = $urandom_range(0, 15);
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
            else if (kind == 1)
            begin
                send_byte(HDR_FIRST);
                send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                pick_angles(fw, lw);
                send_packet(8'($urandom_range(0, 255)), pick_count(), fw, lw,
                            $urandom_range(0, 7) == 0);
            end
            iter++;
        end

        // Drain, then allow the block's own latency for stray reports.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("lidar_scan_packet_deframer test passed");
        else
            $display("lidar_scan_packet_deframer test failed");
        $finish;
    end

    // Receiver: random gap per item, runs of no gap, and one long hold-off
    // on request while the sender keeps pushing bytes.
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            if ($urandom_range(0, 15) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 3);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Watchdog: too long with no item moving on either side.
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("lidar_scan_packet_deframer test failed");
        $finish;
    end

endmodule
